// ----- design/frc_pkg.sv -----
// Shared widths, constants and tables of the Fresnel reflectance unit.
`default_nettype none
package frc_pkg;

  localparam int IDX_W = 16;
  localparam int ANG_W = 15;
  localparam int REF_W = 16;
  localparam int CX_W  = 34;
  localparam int CZ_W  = 33;
  localparam int UNIT_W = 31;

  localparam int TRIG_ITER_DEFAULT = 16;
  localparam int TRIG_ITER_MAX     = 24;

  localparam int DIV_S_STEPS = 34;
  localparam int SQRT_STEPS  = 31;
  localparam int RDIV_STEPS  = 31;

  localparam logic [IDX_W-1:0] MIN_INDEX   = 16'd4096;
  localparam logic [ANG_W-1:0] HALF_PI_Q14 = 15'd25736;
  localparam logic [REF_W-1:0] ONE_Q15     = 16'd32768;
  localparam logic [UNIT_W-1:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [CX_W-1:0] CORDIC_GAIN  = 34'd652032874;

  localparam logic [CZ_W-1:0] ATAN_TAB [0:TRIG_ITER_MAX-1] = '{
    33'd843314856, 33'd497837829, 33'd263043836, 33'd133525158, 33'd67021686,
    33'd33543515, 33'd16775850, 33'd8388437, 33'd4194282, 33'd2097149,
    33'd1048575, 33'd524287, 33'd262143, 33'd131071, 33'd65535, 33'd32767,
    33'd16383, 33'd8191, 33'd4095, 33'd2047, 33'd1023, 33'd511, 33'd255,
    33'd127
  };

  typedef struct packed {
    logic [ANG_W-1:0] transmit_angle;
    logic [REF_W-1:0] refl_s;
    logic [REF_W-1:0] refl_p;
    logic [REF_W-1:0] refl_mean;
    logic [REF_W-1:0] trans_s;
    logic [REF_W-1:0] trans_p;
    logic             total_reflection;
  } result_t;

endpackage
`default_nettype wire

// ----- design/frc_in_if.sv -----
// Request channel of the Fresnel reflectance unit.
`default_nettype none
interface frc_in_if;
  import frc_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index_incident;
  logic [IDX_W-1:0] index_transmit;
  logic [ANG_W-1:0] incidence_angle;
  modport source(output valid, index_incident, index_transmit, incidence_angle, input ready);
  modport sink(input valid, index_incident, index_transmit, incidence_angle, output ready);
endinterface
`default_nettype wire

// ----- design/frc_out_if.sv -----
// Result channel of the Fresnel reflectance unit.
`default_nettype none
interface frc_out_if;
  import frc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ANG_W-1:0] transmit_angle;
  logic [REF_W-1:0] refl_s;
  logic [REF_W-1:0] refl_p;
  logic [REF_W-1:0] refl_mean;
  logic [REF_W-1:0] trans_s;
  logic [REF_W-1:0] trans_p;
  logic             total_reflection;
  modport source(output valid, transmit_angle, refl_s, refl_p, refl_mean, trans_s, trans_p,
                 total_reflection, input ready);
  modport sink(input valid, transmit_angle, refl_s, refl_p, refl_mean, trans_s, trans_p,
               total_reflection, output ready);
endinterface
`default_nettype wire

// ----- design/frc_cordic_cell.sv -----
// One CORDIC micro-rotation cell, in rotation or vectoring mode.
`default_nettype none
module frc_cordic_cell #(
  parameter int SHIFT = 0,
  parameter logic [frc_pkg::CZ_W-1:0] ATAN = '0,
  parameter bit VECTOR = 1'b0,
  parameter type side_t = logic
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [frc_pkg::CX_W-1:0]   x_i,
  input  wire logic signed [frc_pkg::CX_W-1:0]   y_i,
  input  wire logic signed [frc_pkg::CZ_W-1:0]   z_i,
  input  wire side_t                             side_i,
  output logic signed [frc_pkg::CX_W-1:0]        x_o,
  output logic signed [frc_pkg::CX_W-1:0]        y_o,
  output logic signed [frc_pkg::CZ_W-1:0]        z_o,
  output side_t                                  side_o
);
  import frc_pkg::*;

  logic signed [CX_W-1:0] xs, ys, x_r, y_r;
  logic signed [CZ_W-1:0] z_r;
  side_t                  side_r;
  logic                   up;

  assign xs = x_i >>> SHIFT;
  assign ys = y_i >>> SHIFT;
  assign up = VECTOR ? y_i[CX_W-1] : !z_i[CZ_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= up ? x_i - ys : x_i + ys;
      y_r    <= up ? y_i + xs : y_i - xs;
      z_r    <= up ? z_i - $signed(ATAN) : z_i + $signed(ATAN);
      side_r <= side_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

// ----- design/frc_div_cell.sv -----
// One restoring-division cell that yields one quotient bit.
`default_nettype none
module frc_div_cell #(
  parameter int DW = 16,
  parameter int NW = 34,
  parameter int QW = 34,
  parameter type side_t = logic
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [QW-1:0] q_i,
  input  wire side_t         side_i,
  output logic [DW-1:0]      den_o,
  output logic [DW-1:0]      rem_o,
  output logic [NW-1:0]      num_o,
  output logic [QW-1:0]      q_o,
  output side_t              side_o
);
  logic [DW:0]   t;
  logic          ge;
  logic [DW-1:0] den_r, rem_r;
  logic [NW-1:0] num_r;
  logic [QW-1:0] q_r;
  side_t         side_r;

  assign t  = {rem_i, num_i[NW-1]};
  assign ge = t >= {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= den_i;
      rem_r  <= ge ? DW'(t - {1'b0, den_i}) : t[DW-1:0];
      num_r  <= num_i << 1;
      q_r    <= {q_i[QW-2:0], ge};
      side_r <= side_i;
    end
  end

  assign den_o  = den_r;
  assign rem_o  = rem_r;
  assign num_o  = num_r;
  assign q_o    = q_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

// ----- design/frc_sqrt_cell.sv -----
// One digit-by-digit square root cell that yields one root bit.
`default_nettype none
module frc_sqrt_cell #(
  parameter int RW = 33,
  parameter int NW = 62,
  parameter int QW = 31,
  parameter type side_t = logic
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [RW-1:0] rem_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [QW-1:0] root_i,
  input  wire side_t         side_i,
  output logic [RW-1:0]      rem_o,
  output logic [NW-1:0]      num_o,
  output logic [QW-1:0]      root_o,
  output side_t              side_o
);
  logic [RW+1:0] t, trial;
  logic          ge;
  logic [RW-1:0] rem_r;
  logic [NW-1:0] num_r;
  logic [QW-1:0] root_r;
  side_t         side_r;

  assign t     = {rem_i, num_i[NW-1:NW-2]};
  assign trial = (RW+2)'({root_i, 2'b01});
  assign ge    = t >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? RW'(t - trial) : RW'(t);
      num_r  <= num_i << 2;
      root_r <= {root_i[QW-2:0], ge};
      side_r <= side_i;
    end
  end

  assign rem_o  = rem_r;
  assign num_o  = num_r;
  assign root_o = root_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

// ----- design/fresnel_reflectance_unit.sv -----
// Top level of the pipelined Fresnel reflectance unit for dielectric interfaces.
// Each request on in_chan carries two refractive indices (Q4.12) and an incidence
// angle (Q1.14 radians). Each request gives exactly one result on out_chan: the
// transmission angle, the s and p reflectances, their mean, both transmittances
// and a total internal reflection flag.
// The unit is a row of cells: CORDIC rotation cells, a divider for Snell's law,
// a square root, CORDIC vectoring cells and two dividers for the amplitude ratios.
// It takes a new request in every cycle while the skid register is empty.
// When out_chan stalls, one more result is caught in a skid register and the whole
// row then holds; in_chan.ready drops until the skid register drains.
// Reset clears all valid flags; data registers are not reset.
`default_nettype none
module fresnel_reflectance_unit #(
  parameter int TRIG_ITERATIONS = frc_pkg::TRIG_ITER_DEFAULT
) (
  input wire logic clk,
  input wire logic rst_n,
  frc_in_if.sink   in_chan,
  frc_out_if.source out_chan
);
  import frc_pkg::*;

  localparam int NIT = (TRIG_ITERATIONS > TRIG_ITER_MAX) ? TRIG_ITER_MAX :
                       (TRIG_ITERATIONS < 0) ? 0 : TRIG_ITERATIONS;
  localparam int LAT = 6 + 2 * NIT + DIV_S_STEPS + SQRT_STEPS + RDIV_STEPS;
  localparam logic [61:0] RND = 62'd1 << 44;

  typedef struct packed {
    logic [IDX_W-1:0] n1;
    logic [IDX_W-1:0] n2;
  } sb_rot_t;
  typedef struct packed {
    logic [IDX_W-1:0]  n1;
    logic [UNIT_W-1:0] ci;
  } sb_div_t;
  typedef struct packed {
    logic [IDX_W-1:0]  n1;
    logic [IDX_W-1:0]  n2;
    logic [UNIT_W-1:0] ci;
    logic [UNIT_W-1:0] s;
    logic              tir;
  } sb_sqrt_t;
  typedef struct packed {
    logic [IDX_W-1:0]  n1;
    logic [IDX_W-1:0]  n2;
    logic [UNIT_W-1:0] ci;
    logic [UNIT_W-1:0] ct;
    logic              tir;
  } sb_vec_t;
  typedef struct packed {
    logic [ANG_W-1:0] ta;
    logic             tir;
    logic             zs;
  } sb_rdiv_t;

  function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [CX_W-1:0] v);
    logic [UNIT_W-1:0] r;
    if (v[CX_W-1]) begin
      r = '0;
    end else if (v > $signed({3'b0, ONE_Q30})) begin
      r = ONE_Q30;
    end else begin
      r = v[UNIT_W-1:0];
    end
    return r;
  endfunction

  result_t out_r, skid_r;
  logic    out_v_r, skid_v_r, new_res;
  logic adv, in_fire;
  logic [LAT-1:0] vld_r;

  assign adv           = !skid_v_r;
  assign in_chan.ready = adv;
  assign in_fire       = in_chan.valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_fire};
    end
  end

  // Input stage.
  logic [IDX_W-1:0] n1_r, n2_r;
  logic [ANG_W-1:0] ang_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_r  <= (in_chan.index_incident < MIN_INDEX) ? MIN_INDEX : in_chan.index_incident;
      n2_r  <= (in_chan.index_transmit < MIN_INDEX) ? MIN_INDEX : in_chan.index_transmit;
      ang_r <= (in_chan.incidence_angle > HALF_PI_Q14) ? HALF_PI_Q14
                                                       : in_chan.incidence_angle;
    end
  end

  // Rotation CORDIC: sin and cos of the incidence angle.
  logic signed [CX_W-1:0] rx [0:NIT];
  logic signed [CX_W-1:0] ry [0:NIT];
  logic signed [CZ_W-1:0] rz [0:NIT];
  sb_rot_t                rsb [0:NIT];

  assign rx[0]  = $signed(CORDIC_GAIN);
  assign ry[0]  = '0;
  assign rz[0]  = $signed({2'b0, ang_r, 16'b0});
  assign rsb[0] = '{n1: n1_r, n2: n2_r};

  for (genvar k = 0; k < NIT; k++) begin : g_rot
    frc_cordic_cell #(.SHIFT(k), .ATAN(ATAN_TAB[k]), .VECTOR(1'b0), .side_t(sb_rot_t)) u_cell (
      .clk(clk), .en(adv),
      .x_i(rx[k]), .y_i(ry[k]), .z_i(rz[k]), .side_i(rsb[k]),
      .x_o(rx[k+1]), .y_o(ry[k+1]), .z_o(rz[k+1]), .side_o(rsb[k+1])
    );
  end

  // n1 * sin_i.
  logic [45:0]       prod_r;
  logic [UNIT_W-1:0] ci_r;
  sb_rot_t           p1_sb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= 46'(rsb[NIT].n1) * 46'(clamp_unit(ry[NIT]));
      ci_r    <= clamp_unit(rx[NIT]);
      p1_sb_r <= rsb[NIT];
    end
  end

  // Snell's law division by n2.
  logic [IDX_W-1:0]       dv_den [0:DIV_S_STEPS];
  logic [IDX_W-1:0]       dv_rem [0:DIV_S_STEPS];
  logic [DIV_S_STEPS-1:0] dv_num [0:DIV_S_STEPS];
  logic [DIV_S_STEPS-1:0] dv_q   [0:DIV_S_STEPS];
  sb_div_t                dv_sb  [0:DIV_S_STEPS];

  assign dv_den[0] = p1_sb_r.n2;
  assign dv_rem[0] = {4'b0, prod_r[45:34]};
  assign dv_num[0] = prod_r[33:0];
  assign dv_q[0]   = '0;
  assign dv_sb[0]  = '{n1: p1_sb_r.n1, ci: ci_r};

  for (genvar k = 0; k < DIV_S_STEPS; k++) begin : g_sdiv
    frc_div_cell #(.DW(IDX_W), .NW(DIV_S_STEPS), .QW(DIV_S_STEPS), .side_t(sb_div_t)) u_cell (
      .clk(clk), .en(adv),
      .den_i(dv_den[k]), .rem_i(dv_rem[k]), .num_i(dv_num[k]), .q_i(dv_q[k]),
      .side_i(dv_sb[k]),
      .den_o(dv_den[k+1]), .rem_o(dv_rem[k+1]), .num_o(dv_num[k+1]), .q_o(dv_q[k+1]),
      .side_o(dv_sb[k+1])
    );
  end

  // Total reflection test and s squared.
  logic              s_tir;
  logic [UNIT_W-1:0] s_val;
  logic [61:0]       sq_r;
  sb_sqrt_t          p2_sb_r;

  assign s_tir = dv_q[DIV_S_STEPS] > {3'b0, ONE_Q30};
  assign s_val = s_tir ? '0 : dv_q[DIV_S_STEPS][UNIT_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r    <= s_val * s_val;
      p2_sb_r <= '{n1: dv_sb[DIV_S_STEPS].n1, n2: dv_den[DIV_S_STEPS],
                   ci: dv_sb[DIV_S_STEPS].ci, s: s_val, tir: s_tir};
    end
  end

  // cos_t = sqrt(1 - s^2).
  logic [32:0]         sr_rem  [0:SQRT_STEPS];
  logic [61:0]         sr_num  [0:SQRT_STEPS];
  logic [UNIT_W-1:0]   sr_root [0:SQRT_STEPS];
  sb_sqrt_t            sr_sb   [0:SQRT_STEPS];

  assign sr_rem[0]  = '0;
  assign sr_num[0]  = {1'b0, 61'(61'd1 << 60) - sq_r[60:0]};
  assign sr_root[0] = '0;
  assign sr_sb[0]   = p2_sb_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    frc_sqrt_cell #(.RW(33), .NW(62), .QW(UNIT_W), .side_t(sb_sqrt_t)) u_cell (
      .clk(clk), .en(adv),
      .rem_i(sr_rem[k]), .num_i(sr_num[k]), .root_i(sr_root[k]), .side_i(sr_sb[k]),
      .rem_o(sr_rem[k+1]), .num_o(sr_num[k+1]), .root_o(sr_root[k+1]), .side_o(sr_sb[k+1])
    );
  end

  // Vectoring CORDIC: transmission angle.
  logic signed [CX_W-1:0] vx [0:NIT];
  logic signed [CX_W-1:0] vy [0:NIT];
  logic signed [CZ_W-1:0] vz [0:NIT];
  sb_vec_t                vsb [0:NIT];

  assign vx[0]  = $signed({3'b0, sr_root[SQRT_STEPS]});
  assign vy[0]  = $signed({3'b0, sr_sb[SQRT_STEPS].s});
  assign vz[0]  = '0;
  assign vsb[0] = '{n1: sr_sb[SQRT_STEPS].n1, n2: sr_sb[SQRT_STEPS].n2,
                    ci: sr_sb[SQRT_STEPS].ci, ct: sr_root[SQRT_STEPS],
                    tir: sr_sb[SQRT_STEPS].tir};

  for (genvar k = 0; k < NIT; k++) begin : g_vec
    frc_cordic_cell #(.SHIFT(k), .ATAN(ATAN_TAB[k]), .VECTOR(1'b1), .side_t(sb_vec_t)) u_cell (
      .clk(clk), .en(adv),
      .x_i(vx[k]), .y_i(vy[k]), .z_i(vz[k]), .side_i(vsb[k]),
      .x_o(vx[k+1]), .y_o(vy[k+1]), .z_o(vz[k+1]), .side_o(vsb[k+1])
    );
  end

  // Angle rounding and the four index-cosine products.
  logic [CZ_W-2:0]  zpos;
  logic [CZ_W-1:0]  ta_wide;
  logic [ANG_W-1:0] ta_r;
  logic             tir4_r;
  logic [29:0]      as_r, bs_r, ap_r, bp_r;
  logic [46:0]      m_as, m_bs, m_ap, m_bp;

  assign zpos    = vz[NIT][CZ_W-1] ? '0 : vz[NIT][CZ_W-2:0];
  assign ta_wide = ({1'b0, zpos} + CZ_W'(32768)) >> 16;
  assign m_as    = vsb[NIT].n1 * vsb[NIT].ci;
  assign m_bs    = vsb[NIT].n2 * vsb[NIT].ct;
  assign m_ap    = vsb[NIT].n1 * vsb[NIT].ct;
  assign m_bp    = vsb[NIT].n2 * vsb[NIT].ci;

  always_ff @(posedge clk) begin
    if (adv) begin
      ta_r   <= (ta_wide > CZ_W'(HALF_PI_Q14)) ? HALF_PI_Q14 : ta_wide[ANG_W-1:0];
      tir4_r <= vsb[NIT].tir;
      as_r   <= m_as[45:16];
      bs_r   <= m_bs[45:16];
      ap_r   <= m_ap[45:16];
      bp_r   <= m_bp[45:16];
    end
  end

  // Differences and sums of each pair.
  logic [29:0]       ds_r, dp_r;
  logic [UNIT_W-1:0] us_r, up_r;
  sb_rdiv_t          p5_sb_r;
  logic              zp5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_r    <= (as_r >= bs_r) ? as_r - bs_r : bs_r - as_r;
      dp_r    <= (ap_r >= bp_r) ? ap_r - bp_r : bp_r - ap_r;
      us_r    <= {1'b0, as_r} + {1'b0, bs_r};
      up_r    <= {1'b0, ap_r} + {1'b0, bp_r};
      p5_sb_r <= '{ta: ta_r, tir: tir4_r, zs: (as_r == '0) && (bs_r == '0)};
      zp5_r   <= (ap_r == '0) && (bp_r == '0);
    end
  end

  // Amplitude ratio dividers, one lane per polarization.
  logic [UNIT_W-1:0] qs_den [0:RDIV_STEPS], qp_den [0:RDIV_STEPS];
  logic [UNIT_W-1:0] qs_rem [0:RDIV_STEPS], qp_rem [0:RDIV_STEPS];
  logic [UNIT_W-1:0] qs_num [0:RDIV_STEPS], qp_num [0:RDIV_STEPS];
  logic [UNIT_W-1:0] qs_q   [0:RDIV_STEPS], qp_q   [0:RDIV_STEPS];
  sb_rdiv_t          qs_sb  [0:RDIV_STEPS];
  logic              qp_sb  [0:RDIV_STEPS];

  assign qs_den[0] = us_r;
  assign qs_rem[0] = {2'b0, ds_r[29:1]};
  assign qs_num[0] = {ds_r[0], 30'b0};
  assign qs_q[0]   = '0;
  assign qs_sb[0]  = p5_sb_r;
  assign qp_den[0] = up_r;
  assign qp_rem[0] = {2'b0, dp_r[29:1]};
  assign qp_num[0] = {dp_r[0], 30'b0};
  assign qp_q[0]   = '0;
  assign qp_sb[0]  = zp5_r;

  for (genvar k = 0; k < RDIV_STEPS; k++) begin : g_rdiv
    frc_div_cell #(.DW(UNIT_W), .NW(UNIT_W), .QW(UNIT_W), .side_t(sb_rdiv_t)) u_s (
      .clk(clk), .en(adv),
      .den_i(qs_den[k]), .rem_i(qs_rem[k]), .num_i(qs_num[k]), .q_i(qs_q[k]),
      .side_i(qs_sb[k]),
      .den_o(qs_den[k+1]), .rem_o(qs_rem[k+1]), .num_o(qs_num[k+1]), .q_o(qs_q[k+1]),
      .side_o(qs_sb[k+1])
    );
    frc_div_cell #(.DW(UNIT_W), .NW(UNIT_W), .QW(UNIT_W), .side_t(logic)) u_p (
      .clk(clk), .en(adv),
      .den_i(qp_den[k]), .rem_i(qp_rem[k]), .num_i(qp_num[k]), .q_i(qp_q[k]),
      .side_i(qp_sb[k]),
      .den_o(qp_den[k+1]), .rem_o(qp_rem[k+1]), .num_o(qp_num[k+1]), .q_o(qp_q[k+1]),
      .side_o(qp_sb[k+1])
    );
  end

  // Squares of the ratios.
  logic [61:0] qqs_r, qqp_r;
  sb_rdiv_t    p6_sb_r;
  logic        zp6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      qqs_r   <= qs_q[RDIV_STEPS] * qs_q[RDIV_STEPS];
      qqp_r   <= qp_q[RDIV_STEPS] * qp_q[RDIV_STEPS];
      p6_sb_r <= qs_sb[RDIV_STEPS];
      zp6_r   <= qp_sb[RDIV_STEPS];
    end
  end

  // Final scaling, saturation and the result word.
  logic [61:0]      rs_w, rp_w;
  logic [REF_W-1:0] rs, rp;
  logic [REF_W:0]   rsum;
  result_t          res;

  assign rs_w = (qqs_r + RND) >> 45;
  assign rp_w = (qqp_r + RND) >> 45;
  assign rs   = (p6_sb_r.zs || rs_w > 62'(ONE_Q15)) ? ONE_Q15 : rs_w[REF_W-1:0];
  assign rp   = (zp6_r || rp_w > 62'(ONE_Q15)) ? ONE_Q15 : rp_w[REF_W-1:0];
  assign rsum = {1'b0, rs} + {1'b0, rp};

  always_comb begin
    if (p6_sb_r.tir) begin
      res = '{transmit_angle: HALF_PI_Q14, refl_s: ONE_Q15, refl_p: ONE_Q15,
              refl_mean: ONE_Q15, trans_s: '0, trans_p: '0, total_reflection: 1'b1};
    end else begin
      res = '{transmit_angle: p6_sb_r.ta, refl_s: rs, refl_p: rp,
              refl_mean: rsum[REF_W:1], trans_s: ONE_Q15 - rs, trans_p: ONE_Q15 - rp,
              total_reflection: 1'b0};
    end
  end

  // Output register with skid stage.
  assign new_res = adv && vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_chan.ready) begin
      if (new_res) begin
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_r    <= skid_r;
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= new_res;
      if (new_res) begin
        out_r <= res;
      end
    end
  end

  assign out_chan.valid            = out_v_r;
  assign out_chan.transmit_angle   = out_r.transmit_angle;
  assign out_chan.refl_s           = out_r.refl_s;
  assign out_chan.refl_p           = out_r.refl_p;
  assign out_chan.refl_mean        = out_r.refl_mean;
  assign out_chan.trans_s          = out_r.trans_s;
  assign out_chan.trans_p          = out_r.trans_p;
  assign out_chan.total_reflection = out_r.total_reflection;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register empty");

  a_tir_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.total_reflection) |->
      (out_r.refl_s == ONE_Q15 && out_r.refl_p == ONE_Q15 &&
       out_r.transmit_angle == HALF_PI_Q14))
    else $error("total reflection result not saturated");

  a_energy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((17'(out_r.refl_s) + 17'(out_r.trans_s)) == 17'(ONE_Q15) &&
                 (17'(out_r.refl_p) + 17'(out_r.trans_p)) == 17'(ONE_Q15)))
    else $error("reflectance and transmittance do not add to one");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_chan.ready) |=> (skid_v_r && $stable(skid_r)))
    else $error("skid register lost a held result");
endmodule
`default_nettype wire
